// File: sv/pip_pkg.sv
// Shared constants and the controller-to-datapath command type of the polygon hit test.
package pip_pkg;

	localparam int SCALE_W    = 16;
	localparam int SCALE_FRAC = 8;
	localparam int DIGIT_W    = 16;

	typedef struct packed {
		logic load_query;
		logic capture;
		logic map;
		logic first_en;
		logic setup;
		logic edge_sel;
		logic mul_go;
		logic mul_pair;
		logic acc_go;
		logic eval;
		logic commit;
		logic emit;
	} dp_cmd_t;

endpackage

// File: sv/pip_dp.sv
// Datapath: query registers, vertex mapping, edge operands, digit multiplier and parity.
module pip_dp import pip_pkg::*; #(
	parameter int COORD_WIDTH = 24,
	localparam int DW  = COORD_WIDTH + SCALE_W + 3,
	localparam int ND  = (DW + DIGIT_W - 1) / DIGIT_W,
	localparam int DIW = $clog2(ND)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	input  logic [DIW-1:0]                digit,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] offset_x,
	input  logic signed [COORD_WIDTH-1:0] offset_y,
	input  logic [SCALE_W-1:0]            scale,
	output logic                          inside_res
);

	localparam int VW  = COORD_WIDTH + SCALE_W + 2;
	localparam int MW  = COORD_WIDTH + SCALE_W + 1;
	localparam int PW  = ND * DIGIT_W;
	localparam int PRW = DW + DIGIT_W + 1;
	localparam int AW  = 2 * DW;
	localparam logic [DIW-1:0] DIG_LAST = DIW'(ND - 1);

	logic signed [COORD_WIDTH-1:0] query_x_q, query_y_q, shift_x_q, shift_y_q;
	logic [SCALE_W-1:0]            scale_q;
	logic                          parity_q;
	logic                          inside_q;

	logic signed [COORD_WIDTH-1:0] cx_q, cy_q;
	logic signed [VW-1:0]          cur_x_q, cur_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [DW-1:0]          a1_q, b1_q, a2_q, b2_q;
	logic                          straddle_q, dypos_q;
	logic signed [PRW-1:0]         prod_s1;
	logic [DIW-1:0]                digit_s1;
	logic                          pair_s1;
	logic signed [AW-1:0]          acc_q;

	logic signed [SCALE_W:0]       sc17;
	logic signed [MW-1:0]          mx, my;
	logic signed [VW-1:0]          map_x, map_y;
	logic signed [VW-1:0]          px, py;
	logic signed [VW-1:0]          xi, yi, xj, yj;
	logic signed [DW-1:0]          a_sel, b_sel;
	logic signed [PW-1:0]          bpad;
	logic [DIGIT_W-1:0]            dseg;
	logic signed [DIGIT_W:0]       d17;
	logic signed [PRW-1:0]         prod;
	logic signed [AW-1:0]          term;
	logic                          acc_neg, toggle;

	assign sc17  = $signed({1'b0, scale_q});
	assign mx    = cx_q * sc17;
	assign my    = cy_q * sc17;
	assign map_x = (VW'(shift_x_q) <<< SCALE_FRAC) + VW'(mx);
	assign map_y = (VW'(shift_y_q) <<< SCALE_FRAC) + VW'(my);

	assign px = VW'(query_x_q) <<< SCALE_FRAC;
	assign py = VW'(query_y_q) <<< SCALE_FRAC;

	assign xi = cmd.edge_sel ? first_x_q : cur_x_q;
	assign yi = cmd.edge_sel ? first_y_q : cur_y_q;
	assign xj = cmd.edge_sel ? cur_x_q : prev_x_q;
	assign yj = cmd.edge_sel ? cur_y_q : prev_y_q;

	assign a_sel = cmd.mul_pair ? a2_q : a1_q;
	assign b_sel = cmd.mul_pair ? b2_q : b1_q;
	assign bpad  = PW'(b_sel);
	assign dseg  = bpad[digit * DIGIT_W +: DIGIT_W];
	assign d17   = $signed({(digit == DIG_LAST) ? dseg[DIGIT_W-1] : 1'b0, dseg});
	assign prod  = a_sel * d17;

	assign term    = AW'(prod_s1) <<< (DIGIT_W * digit_s1);
	assign acc_neg = acc_q[AW-1];
	assign toggle  = straddle_q && (dypos_q ? acc_neg : (!acc_neg && (acc_q != '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
			shift_x_q <= '0;
			shift_y_q <= '0;
			scale_q   <= '0;
			parity_q  <= 1'b0;
		end else begin
			if (cmd.load_query) begin
				query_x_q <= coord_x;
				query_y_q <= coord_y;
				shift_x_q <= offset_x;
				shift_y_q <= offset_y;
				scale_q   <= scale;
				parity_q  <= 1'b0;
			end
			if (cmd.eval && toggle) begin
				parity_q <= !parity_q;
			end
			if (cmd.emit) begin
				parity_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cx_q <= coord_x;
			cy_q <= coord_y;
		end
		if (cmd.map) begin
			cur_x_q <= map_x;
			cur_y_q <= map_y;
			if (cmd.first_en) begin
				first_x_q <= map_x;
				first_y_q <= map_y;
			end
		end
		if (cmd.setup) begin
			a1_q       <= DW'(px) - DW'(xi);
			b1_q       <= DW'(yj) - DW'(yi);
			a2_q       <= DW'(xj) - DW'(xi);
			b2_q       <= DW'(py) - DW'(yi);
			straddle_q <= (yi > py) != (yj > py);
			dypos_q    <= yj > yi;
			acc_q      <= '0;
		end
		if (cmd.mul_go) begin
			prod_s1  <= prod;
			digit_s1 <= digit;
			pair_s1  <= cmd.mul_pair;
		end
		if (cmd.acc_go) begin
			acc_q <= pair_s1 ? acc_q - term : acc_q + term;
		end
		if (cmd.commit) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (cmd.emit) begin
			inside_q <= parity_q;
		end
	end

	assign inside_res = inside_q;

endmodule

// File: sv/pip_ctrl.sv
// Controller: sequences map, edge setup, digit multiply and parity update per transaction.
module pip_ctrl import pip_pkg::*; #(
	parameter int COORD_WIDTH = 24,
	localparam int DW  = COORD_WIDTH + SCALE_W + 3,
	localparam int ND  = (DW + DIGIT_W - 1) / DIGIT_W,
	localparam int DIW = $clog2(ND)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           req_type,
	input  logic           last_vertex,
	output logic           out_valid,
	input  logic           out_stall,
	output dp_cmd_t        cmd,
	output logic [DIW-1:0] digit
);

	localparam logic [DIW-1:0] DIG_LAST = DIW'(ND - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAP,
		S_SETUP,
		S_MUL,
		S_DRAIN,
		S_EVAL,
		S_STORE,
		S_EMIT
	} state_t;

	state_t         state_q;
	logic           last_q;
	logic           have_first_q;
	logic           sel_q;
	logic           pair_q;
	logic [DIW-1:0] digit_q;
	logic           out_valid_q;
	logic           slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_query = in_valid && !req_type;
				cmd.capture    = in_valid && req_type;
			end
			S_MAP: begin
				cmd.map      = 1'b1;
				cmd.first_en = !have_first_q;
			end
			S_SETUP: begin
				cmd.setup    = 1'b1;
				cmd.edge_sel = sel_q;
			end
			S_MUL: begin
				cmd.mul_go   = 1'b1;
				cmd.mul_pair = pair_q;
				cmd.acc_go   = pair_q || (digit_q != '0);
			end
			S_DRAIN: cmd.acc_go = 1'b1;
			S_EVAL:  cmd.eval = 1'b1;
			S_STORE: cmd.commit = 1'b1;
			S_EMIT:  cmd.emit = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_q       <= 1'b0;
			have_first_q <= 1'b0;
			sel_q        <= 1'b0;
			pair_q       <= 1'b0;
			digit_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= last_vertex;
						if (!req_type) begin
							have_first_q <= 1'b0;
							state_q      <= last_vertex ? S_EMIT : S_IDLE;
						end else begin
							state_q <= S_MAP;
						end
					end
				end
				S_MAP: begin
					have_first_q <= 1'b1;
					pair_q       <= 1'b0;
					digit_q      <= '0;
					if (have_first_q) begin
						sel_q   <= 1'b0;
						state_q <= S_SETUP;
					end else if (last_q) begin
						sel_q   <= 1'b1;
						state_q <= S_SETUP;
					end else begin
						state_q <= S_STORE;
					end
				end
				S_SETUP: state_q <= S_MUL;
				S_MUL: begin
					if (digit_q == DIG_LAST) begin
						digit_q <= '0;
						if (pair_q) begin
							state_q <= S_DRAIN;
						end else begin
							pair_q <= 1'b1;
						end
					end else begin
						digit_q <= digit_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_EVAL;
				S_EVAL: begin
					if (!sel_q && last_q) begin
						sel_q   <= 1'b1;
						pair_q  <= 1'b0;
						state_q <= S_SETUP;
					end else begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (last_q) begin
						have_first_q <= 1'b0;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign digit     = digit_q;

endmodule

// File: sv/point_in_polygon_test_top.sv
// Even-odd point-in-polygon hit test: controller, datapath and result checks.
// A begin transaction loads the test point, offset and scale; with last_vertex set
// it also posts the result of an empty polygon. Each vertex transaction is mapped to
// offset + vertex * scale, then every edge it closes is tested with an exact
// cross-multiplied compare formed on one shared multiplier that takes the multiplier
// operand 16 bits per cycle, in ND = ceil((COORD_WIDTH + 19) / 16) digits. An edge
// runs setup, the digits of both products, an accumulator drain and the parity
// update; the last vertex also closes the edge back to the first vertex before its
// result is posted. A new transaction is accepted while a posted result waits to be
// taken.
module point_in_polygon_test_top import pip_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] offset_x,
	input  logic signed [COORD_WIDTH-1:0] offset_y,
	input  logic [SCALE_W-1:0]            scale,
	input  logic                          last_vertex,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          inside_res
);

	localparam int DW  = COORD_WIDTH + SCALE_W + 3;
	localparam int ND  = (DW + DIGIT_W - 1) / DIGIT_W;
	localparam int DIW = $clog2(ND);

	dp_cmd_t        cmd;
	logic [DIW-1:0] digit;

	pip_ctrl #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.last_vertex(last_vertex),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.digit      (digit)
	);

	pip_dp #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.digit     (digit),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.offset_x  (offset_x),
		.offset_y  (offset_y),
		.scale     (scale),
		.inside_res(inside_res)
	);

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && out_stall))
		else $error("result posted over a waiting result");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !(cmd.map || cmd.setup || cmd.mul_go || cmd.acc_go || cmd.eval))
		else $error("transaction accepted while datapath busy");

	a_eval_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> $past(cmd.acc_go) && !$past(cmd.mul_go))
		else $error("parity update before accumulator drained");

	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_query, cmd.capture, cmd.map, cmd.setup, cmd.mul_go,
			cmd.eval, cmd.commit, cmd.emit}))
		else $error("overlapping datapath commands");

endmodule
